[src/slhe_pkg.sv]
`default_nettype none

package slhe_pkg;

    // operation codes carried on s_axis_tuser
    localparam logic [1:0] OP_BYTE    = 2'd0;
    localparam logic [1:0] OP_FINISH  = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    // geometry of the chaining state and the block buffer
    localparam int NUM_WORDS = 5;
    localparam int BLK_WORDS = 16;
    localparam int CHAIN_AW  = 3;
    localparam int BLK_AW    = 4;

    // word slots of the big-endian bit count in the last padded block
    localparam logic [BLK_AW-1:0] WORD_LEN_HI = 4'd14;
    localparam logic [BLK_AW-1:0] WORD_LEN_LO = 4'd15;

    // first byte position that no longer leaves room for the length
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PAD_ZERO,
        ST_LEN_HI,
        ST_LEN_LO,
        ST_LOAD,
        ST_ROUND,
        ST_SAVE,
        ST_EMIT_RD,
        ST_EMIT_LD
    } slhe_state_t;

    // where the sequencer goes once a block is folded into the chaining words
    typedef enum logic [1:0] {
        RET_IDLE,
        RET_PAD2,
        RET_EMIT
    } slhe_ret_t;

    // working variables of the compression rounds
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
    } slhe_work_t;

    // initial chaining value of one word
    function automatic logic [31:0] slhe_init_word(input logic [CHAIN_AW-1:0] idx);
        logic [31:0] val;
        case (idx)
            3'd0:    val = 32'h67452301;
            3'd1:    val = 32'hEFCDAB89;
            3'd2:    val = 32'h98BADCFE;
            3'd3:    val = 32'h10325476;
            3'd4:    val = 32'hC3D2E1F0;
            default: val = 32'h0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

[src/sha1_like_hash_engine.sv]
`default_nettype none

// channel   dir   tdata                 tuser                 tlast
// s_axis    in    [7:0] data_byte       [1:0] operation       -
// m_axis    out   [31:0] digest_word    [2:0] word_index      last_word
//
// message bytes are taken while the sequencer is idle; every 64th byte starts a block
// that holds tready low through the chaining loads, 16 rounds and the write-backs
// a first finish writes up to 18 padding words, runs one or two blocks and then
// reads the five digest words from chaining memory, a read state and a load state each
// reset clears the sequencer and flags; chaining words read as their initial
// values until written (one valid bit per word), the block buffer is not cleared
// a stalled m_axis holds the digest read-out, s_axis stays blocked meanwhile

module sha1_like_hash_engine
    import slhe_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire  [1:0]  s_axis_tuser,   // [1:0] operation
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,   // [2:0] word_index
    output logic        m_axis_tlast
);

    localparam logic [3:0] CHAIN_END = 4'(NUM_WORDS);
    localparam logic [3:0] ROUND_END = 4'(BLK_WORDS - 1);
    localparam logic [2:0] LAST_IDX  = 3'(NUM_WORDS - 1);

    slhe_state_t            state_reg, state_next;
    slhe_ret_t              ret_reg, ret_next;
    logic [3:0]             cnt_reg, cnt_next;
    logic [4:0]             ptr_reg, ptr_next;
    logic                   two_blk_reg, two_blk_next;
    logic [5:0]             fill_reg, fill_next;
    logic [23:0]            asm_reg, asm_next;
    logic [63:0]            count_reg, count_next;
    logic                   done_reg, done_next;
    logic                   corrupt_reg, corrupt_next;
    logic [NUM_WORDS-1:0]   chain_vld_reg, chain_vld_next;
    logic [CHAIN_AW-1:0]    chain_ra_reg;
    slhe_work_t             work_reg, work_next;
    logic                   out_valid_reg, out_valid_next;
    logic [31:0]            out_word_reg, out_word_next;
    logic [2:0]             out_idx_reg, out_idx_next;
    logic                   out_last_reg, out_last_next;

    logic                   accept;
    logic                   slot_free;
    logic [63:0]            count_sum;
    logic [31:0]            pad_word;
    logic [4:0]             pad_limit;
    logic [31:0]            chain_val;
    slhe_work_t             round_out;

    logic                   buf_we, buf_re;
    logic [BLK_AW-1:0]      buf_wa, buf_ra;
    logic [31:0]            buf_wd, buf_rd;
    logic                   chain_we, chain_re;
    logic [CHAIN_AW-1:0]    chain_wa, chain_ra;
    logic [31:0]            chain_wd, chain_rd;

    // block buffer, one 32-bit big-endian word per entry
    slhe_ram #(
        .WIDTH (32),
        .DEPTH (BLK_WORDS)
    ) u_blk_ram (
        .clk     (clk),
        .wr_en   (buf_we),
        .wr_addr (buf_wa),
        .wr_data (buf_wd),
        .rd_en   (buf_re),
        .rd_addr (buf_ra),
        .rd_data (buf_rd)
    );

    // chaining words
    slhe_ram #(
        .WIDTH (32),
        .DEPTH (NUM_WORDS)
    ) u_chain_ram (
        .clk     (clk),
        .wr_en   (chain_we),
        .wr_addr (chain_wa),
        .wr_data (chain_wd),
        .rd_en   (chain_re),
        .rd_addr (chain_ra),
        .rd_data (chain_rd)
    );

    slhe_round u_round (
        .work_in  (work_reg),
        .msg_word (buf_rd),
        .work_out (round_out)
    );

    // handshake and helpers
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign slot_free     = !out_valid_reg || m_axis_tready;
    assign count_sum     = count_reg + 64'd8;
    assign pad_limit     = two_blk_reg ? 5'(BLK_WORDS) : {1'b0, WORD_LEN_HI};
    assign chain_val     = chain_vld_reg[chain_ra_reg] ? chain_rd : slhe_init_word(chain_ra_reg);

    // partial word closed by the padding byte
    always_comb
    begin
        case (fill_reg[1:0])
            2'd0:    pad_word = {PAD_BYTE, 24'h0};
            2'd1:    pad_word = {asm_reg[7:0], PAD_BYTE, 16'h0};
            2'd2:    pad_word = {asm_reg[15:0], PAD_BYTE, 8'h0};
            default: pad_word = {asm_reg, PAD_BYTE};
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (s_axis_tuser)
                        OP_BYTE:
                        begin
                            if (!done_reg && !corrupt_reg && (fill_reg == 6'd63))
                            begin
                                state_next = ST_LOAD;
                            end
                        end
                        OP_FINISH:
                        begin
                            if (!corrupt_reg)
                            begin
                                state_next = done_reg ? ST_EMIT_RD : ST_PAD_ZERO;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_PAD_ZERO:
            begin
                if (ptr_reg == pad_limit)
                begin
                    state_next = two_blk_reg ? ST_LOAD : ST_LEN_HI;
                end
            end
            ST_LEN_HI:
            begin
                state_next = ST_LEN_LO;
            end
            ST_LEN_LO:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (cnt_reg == CHAIN_END)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                if (cnt_reg == ROUND_END)
                begin
                    state_next = ST_SAVE;
                end
            end
            ST_SAVE:
            begin
                if (cnt_reg == CHAIN_END)
                begin
                    case (ret_reg)
                        RET_PAD2: state_next = ST_PAD_ZERO;
                        RET_EMIT: state_next = ST_EMIT_RD;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                if (slot_free)
                begin
                    state_next = (cnt_reg[2:0] == LAST_IDX) ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath control and memory ports
    always_comb
    begin
        ret_next       = ret_reg;
        cnt_next       = cnt_reg;
        ptr_next       = ptr_reg;
        two_blk_next   = two_blk_reg;
        fill_next      = fill_reg;
        asm_next       = asm_reg;
        count_next     = count_reg;
        done_next      = done_reg;
        corrupt_next   = corrupt_reg;
        chain_vld_next = chain_vld_reg;
        work_next      = work_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_word_next  = out_word_reg;
        out_idx_next   = out_idx_reg;
        out_last_next  = out_last_reg;
        buf_we         = 1'b0;
        buf_wa         = fill_reg[5:2];
        buf_wd         = {asm_reg, s_axis_tdata};
        buf_re         = 1'b0;
        buf_ra         = '0;
        chain_we       = 1'b0;
        chain_wa       = chain_ra_reg;
        chain_wd       = chain_val + work_reg.a;
        chain_re       = 1'b0;
        chain_ra       = cnt_reg[2:0];

        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (accept)
                begin
                    case (s_axis_tuser)
                        OP_BYTE:
                        begin
                            if (done_reg || corrupt_reg)
                            begin
                                corrupt_next = 1'b1;
                            end
                            else
                            begin
                                asm_next   = {asm_reg[15:0], s_axis_tdata};
                                fill_next  = fill_reg + 6'd1;
                                count_next = count_sum;
                                ret_next   = RET_IDLE;
                                if (count_sum == 64'd0)
                                begin
                                    corrupt_next = 1'b1;
                                end
                                // a word is complete every fourth byte
                                if (fill_reg[1:0] == 2'd3)
                                begin
                                    buf_we = 1'b1;
                                end
                            end
                        end
                        OP_FINISH:
                        begin
                            if (!corrupt_reg && !done_reg)
                            begin
                                buf_we       = 1'b1;
                                buf_wd       = pad_word;
                                ptr_next     = {1'b0, fill_reg[5:2]} + 5'd1;
                                two_blk_next = (fill_reg >= LEN_POS);
                            end
                        end
                        OP_RESTART:
                        begin
                            fill_next      = '0;
                            count_next     = '0;
                            done_next      = 1'b0;
                            corrupt_next   = 1'b0;
                            chain_vld_next = '0;
                        end
                        default:
                        begin
                            corrupt_next = corrupt_reg;
                        end
                    endcase
                end
            end
            // zero fill up to the length slot or to the end of the block
            ST_PAD_ZERO:
            begin
                cnt_next = '0;
                if (ptr_reg != pad_limit)
                begin
                    buf_we   = 1'b1;
                    buf_wa   = ptr_reg[BLK_AW-1:0];
                    buf_wd   = '0;
                    ptr_next = ptr_reg + 5'd1;
                end
                else if (two_blk_reg)
                begin
                    ret_next = RET_PAD2;
                end
            end
            ST_LEN_HI:
            begin
                buf_we = 1'b1;
                buf_wa = WORD_LEN_HI;
                buf_wd = count_reg[63:32];
            end
            ST_LEN_LO:
            begin
                buf_we   = 1'b1;
                buf_wa   = WORD_LEN_LO;
                buf_wd   = count_reg[31:0];
                cnt_next = '0;
                ret_next = RET_EMIT;
            end
            // read the chaining words into the working set, prefetch word 0
            ST_LOAD:
            begin
                chain_re = (cnt_reg != CHAIN_END);
                if (cnt_reg != 4'd0)
                begin
                    work_next.a = work_reg.b;
                    work_next.b = work_reg.c;
                    work_next.c = work_reg.d;
                    work_next.d = work_reg.e;
                    work_next.e = chain_val;
                end
                if (cnt_reg == CHAIN_END)
                begin
                    buf_re   = 1'b1;
                    buf_ra   = '0;
                    cnt_next = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            // one round per cycle, next message word fetched alongside
            ST_ROUND:
            begin
                buf_re    = 1'b1;
                buf_ra    = cnt_reg + 4'd1;
                work_next = round_out;
                cnt_next  = cnt_reg + 4'd1;
            end
            // read-modify-write of each chaining word
            ST_SAVE:
            begin
                chain_re = (cnt_reg != CHAIN_END);
                if (cnt_reg != 4'd0)
                begin
                    chain_we                     = 1'b1;
                    chain_vld_next[chain_ra_reg] = 1'b1;
                    work_next.a                  = work_reg.b;
                    work_next.b                  = work_reg.c;
                    work_next.c                  = work_reg.d;
                    work_next.d                  = work_reg.e;
                    work_next.e                  = work_reg.a;
                end
                if (cnt_reg == CHAIN_END)
                begin
                    cnt_next = '0;
                    case (ret_reg)
                        RET_PAD2:
                        begin
                            ptr_next     = '0;
                            two_blk_next = 1'b0;
                        end
                        RET_EMIT:
                        begin
                            done_next = 1'b1;
                        end
                        default:
                        begin
                            fill_next = fill_reg;
                        end
                    endcase
                end
                else
                begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            ST_EMIT_RD:
            begin
                chain_re = 1'b1;
            end
            // hand one digest word to the output register
            ST_EMIT_LD:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = chain_val;
                    out_idx_next   = cnt_reg[2:0];
                    out_last_next  = (cnt_reg[2:0] == LAST_IDX);
                    cnt_next       = cnt_reg + 4'd1;
                end
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ret_reg       <= RET_IDLE;
            cnt_reg       <= '0;
            ptr_reg       <= '0;
            two_blk_reg   <= 1'b0;
            fill_reg      <= '0;
            count_reg     <= '0;
            done_reg      <= 1'b0;
            corrupt_reg   <= 1'b0;
            chain_vld_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            cnt_reg       <= cnt_next;
            ptr_reg       <= ptr_next;
            two_blk_reg   <= two_blk_next;
            fill_reg      <= fill_next;
            count_reg     <= count_next;
            done_reg      <= done_next;
            corrupt_reg   <= corrupt_next;
            chain_vld_reg <= chain_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        asm_reg      <= asm_next;
        work_reg     <= work_next;
        out_word_reg <= out_word_next;
        out_idx_reg  <= out_idx_next;
        out_last_reg <= out_last_next;
        if (chain_re)
        begin
            chain_ra_reg <= chain_ra;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_word_reg;
    assign m_axis_tuser  = out_idx_reg;
    assign m_axis_tlast  = out_last_reg;

    // sixteen rounds between the chaining load and the write-back
    a_round_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD && cnt_reg == CHAIN_END)
        |=> (state_reg == ST_ROUND) ##16 (state_reg == ST_SAVE))
        else $error("block did not run sixteen rounds");

    // corrupt clears only on a restart
    a_corrupt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (corrupt_reg && !(accept && s_axis_tuser == OP_RESTART)) |=> corrupt_reg)
        else $error("corrupt flag dropped without restart");

    // the final digest word carries index four and the last marker
    a_last_word: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT_LD && slot_free && cnt_reg[2:0] == LAST_IDX)
        |=> (out_valid_reg && out_last_reg && state_reg == ST_IDLE))
        else $error("digest read-out ended wrongly");

    // a repeated finish goes straight to the digest read-out
    a_refinish: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_axis_tuser == OP_FINISH && done_reg && !corrupt_reg)
        |=> (state_reg == ST_EMIT_RD))
        else $error("repeated finish did not emit the digest");

endmodule

`default_nettype wire

[src/slhe_ram.sv]
`default_nettype none

module slhe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire                              clk,
    input  wire                              wr_en,
    input  wire  [$clog2(DEPTH)-1:0]         wr_addr,
    input  wire  [WIDTH-1:0]                 wr_data,
    input  wire                              rd_en,
    input  wire  [$clog2(DEPTH)-1:0]         rd_addr,
    output logic [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[src/slhe_round.sv]
`default_nettype none

module slhe_round
    import slhe_pkg::*;
(
    input  slhe_work_t  work_in,
    input  wire  [31:0] msg_word,
    output slhe_work_t  work_out
);

    logic [31:0] choose;
    logic [31:0] sum;

    // choose function and four-operand sum
    assign choose = (work_in.b & work_in.c) | (~work_in.b & work_in.d);
    assign sum    = {work_in.a[26:0], work_in.a[31:27]} + choose + work_in.e + msg_word;

    // rotate and shift the working variables
    assign work_out.a = {sum[26:0], sum[31:27]};
    assign work_out.b = {work_in.a[21:0], work_in.a[31:22]};
    assign work_out.c = {work_in.b[1:0], work_in.b[31:2]};
    assign work_out.d = {work_in.c[16:0], work_in.c[31:17]};
    assign work_out.e = {work_in.d[6:0], work_in.d[31:7]};

endmodule

`default_nettype wire
